// File: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, codes and constants of the bitmap block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

	// default map size in blocks
	localparam int BLOCK_COUNT_DEF = 1024;

	// field widths
	localparam int KIND_W   = 2;
	localparam int NUM_W    = 10;
	localparam int STATUS_W = 2;
	localparam int WORD_W   = 32;
	localparam int BIT_W    = 5;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DOUBLE  = 2'd3;

	// word address update
	localparam logic [1:0] ADDR_HOLD = 2'd0;
	localparam logic [1:0] ADDR_LOAD = 2'd1;
	localparam logic [1:0] ADDR_INC  = 2'd2;
	localparam logic [1:0] ADDR_ZERO = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic       ld_req;   // capture request fields
		logic [1:0] addr_op;  // word address update
		logic       rd_en;    // read map word at next address
		logic       wr_zero;  // write all-zero word at current address
		logic       commit;   // load result, write back modified word
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;      // kind of request in progress
		logic              found;     // current word has a free valid block
		logic              last;      // current word is the last map word
		logic              start_ok;  // first data block lies inside the map
	} stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                                         clk,
	input  wire logic                                         wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                             wr_data,
	input  wire logic                                         rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// allocator datapath: map memory, word scan, request and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dp #(
	parameter int BLOCK_COUNT = bba_pkg::BLOCK_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [bba_pkg::NUM_W-1:0]     cfg_data,
	input  wire logic [bba_pkg::KIND_W-1:0]    in_kind,
	input  wire logic [bba_pkg::NUM_W-1:0]     in_num,
	input  wire bba_pkg::cmd_t                 cmd,
	output bba_pkg::stat_t                     st,
	output logic      [bba_pkg::NUM_W-1:0]     res_num,
	output logic      [bba_pkg::STATUS_W-1:0]  res_status,
	output logic                               res_is_free
);

	localparam int MAP_WORDS = (BLOCK_COUNT + 31) / 32;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int TAIL      = BLOCK_COUNT % 32;
	localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
	// bits of the last word that lie beyond the map
	localparam logic [31:0] TAIL_MASK =
		(TAIL == 0) ? 32'h0 : ~((32'h1 << TAIL) - 32'h1);

	logic [bba_pkg::NUM_W-1:0]    fdb_q;
	logic [bba_pkg::KIND_W-1:0]   kind_q;
	logic [bba_pkg::NUM_W-1:0]    num_q;
	logic [AW-1:0]                addr_q;
	logic [AW-1:0]                addr_d;
	logic [AW-1:0]                fdb_word;
	logic [AW-1:0]                in_word;
	logic [bba_pkg::WORD_W-1:0]   rd_data;
	logic [bba_pkg::WORD_W-1:0]   scan_word;
	logic [bba_pkg::WORD_W-1:0]   wr_data;
	logic [bba_pkg::BIT_W-1:0]    free_idx;
	logic [31:0]                  alloc_num;
	logic                         start_ok;
	logic                         found;
	logic                         num_ok;
	logic                         taken;
	logic                         wr_en;
	logic                         need_wr;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fdb_q <= '0;
		end else if (cfg_valid) begin
			fdb_q <= cfg_data;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			kind_q <= in_kind;
			num_q  <= in_num;
		end
	end

	assign fdb_word = AW'(32'(fdb_q) >> 5);
	assign in_word  = AW'(32'(in_num) >> 5);
	assign start_ok = 32'(fdb_q) < 32'(BLOCK_COUNT);

	always_comb begin
		unique case (cmd.addr_op)
			bba_pkg::ADDR_LOAD: addr_d = (in_kind == bba_pkg::KIND_ALLOC) ? fdb_word : in_word;
			bba_pkg::ADDR_INC:  addr_d = addr_q + AW'(1);
			bba_pkg::ADDR_ZERO: addr_d = '0;
			default:            addr_d = addr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else begin
			addr_q <= addr_d;
		end
	end

	// word scan: blocks below the first data block and past the map count as taken
	always_comb begin
		scan_word = rd_data;
		if (addr_q == fdb_word) begin
			scan_word = scan_word | ((32'h1 << fdb_q[bba_pkg::BIT_W-1:0]) - 32'h1);
		end
		if (addr_q == LAST_WORD) begin
			scan_word = scan_word | TAIL_MASK;
		end
	end

	// lowest zero bit
	always_comb begin
		free_idx = '0;
		for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
			if (!scan_word[i]) begin
				free_idx = bba_pkg::BIT_W'(i);
			end
		end
	end

	assign found     = start_ok && (scan_word != '1);
	assign alloc_num = 32'({addr_q, free_idx});
	assign num_ok    = (num_q >= fdb_q) && (32'(num_q) < 32'(BLOCK_COUNT));
	assign taken     = rd_data[num_q[bba_pkg::BIT_W-1:0]];

	always_comb begin
		need_wr = 1'b0;
		wr_data = rd_data;
		case (kind_q)
			bba_pkg::KIND_ALLOC: begin
				need_wr = found;
				wr_data = rd_data | (32'h1 << free_idx);
			end
			bba_pkg::KIND_FREE: begin
				need_wr = num_ok && taken;
				wr_data = rd_data & ~(32'h1 << num_q[bba_pkg::BIT_W-1:0]);
			end
			default: begin
				need_wr = 1'b0;
			end
		endcase
		if (cmd.wr_zero) begin
			wr_data = '0;
		end
	end

	assign wr_en = cmd.wr_zero || (cmd.commit && need_wr);

	bba_ram #(
		.WIDTH (bba_pkg::WORD_W),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_q),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (addr_d),
		.rd_data (rd_data)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			case (kind_q)
				bba_pkg::KIND_ALLOC: begin
					res_num     <= found ? alloc_num[bba_pkg::NUM_W-1:0] : '0;
					res_status  <= found ? bba_pkg::ST_OK : bba_pkg::ST_FULL;
					res_is_free <= 1'b0;
				end
				bba_pkg::KIND_FREE: begin
					res_num     <= num_q;
					res_status  <= !num_ok ? bba_pkg::ST_INVALID :
					               !taken  ? bba_pkg::ST_DOUBLE  : bba_pkg::ST_OK;
					res_is_free <= 1'b0;
				end
				bba_pkg::KIND_QUERY: begin
					res_num     <= num_q;
					res_status  <= num_ok ? bba_pkg::ST_OK : bba_pkg::ST_INVALID;
					res_is_free <= num_ok && !taken;
				end
				default: begin
					res_num     <= '0;
					res_status  <= bba_pkg::ST_OK;
					res_is_free <= 1'b0;
				end
			endcase
		end
	end

	assign st.kind     = kind_q;
	assign st.found    = found;
	assign st.last     = (addr_q == LAST_WORD);
	assign st.start_ok = start_ok;

endmodule

`default_nettype wire

// File: hw/rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// allocator controller: request sequencing, clearing sweeps, result valid
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [bba_pkg::KIND_W-1:0]  in_kind,
	output logic                             in_ready,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output bba_pkg::cmd_t                    cmd,
	input  wire bba_pkg::stat_t              st
);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_CLEAR = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;
	logic       scan_on;

	assign slot_free = !out_valid_q || out_ready;
	// allocate keeps scanning while no free bit and words remain
	assign scan_on = (st.kind == bba_pkg::KIND_ALLOC) && st.start_ok && !st.found && !st.last;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cmd.wr_zero = 1'b1;
				if (st.last) begin
					state_d = S_IDLE;
				end else begin
					cmd.addr_op = bba_pkg::ADDR_INC;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_req = 1'b1;
					if (in_kind == bba_pkg::KIND_CLEAR) begin
						cmd.addr_op = bba_pkg::ADDR_ZERO;
						state_d     = S_CLEAR;
					end else begin
						cmd.addr_op = bba_pkg::ADDR_LOAD;
						cmd.rd_en   = 1'b1;
						state_d     = S_EVAL;
					end
				end
			end
			S_EVAL: begin
				if (scan_on) begin
					cmd.addr_op = bba_pkg::ADDR_INC;
					cmd.rd_en   = 1'b1;
				end else if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.wr_zero = 1'b1;
				if (st.last) begin
					state_d = S_FIN;
				end else begin
					cmd.addr_op = bba_pkg::ADDR_INC;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// a result is never loaded over one that is still waiting
	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending result");

	// an accepted request goes straight to evaluation or the clearing sweep
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EVAL || state_q == S_CLEAR))
		else $error("accepted request not dispatched");

	// the scan ends at the last map word
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && st.last && slot_free) |=> state_q == S_IDLE)
		else $error("allocate scan ran past the last word");

	// no requests during a clearing sweep
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT || state_q == S_CLEAR) |-> !in_ready && !cmd.commit)
		else $error("request taken during clearing sweep");

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_block_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// first-fit bitmap allocator for storage blocks with a request/result stream
// ----------------------------------------------------------------------------
// The map keeps one taken bit per block in a 32-bit wide memory of
// ceil(BLOCK_COUNT/32) words, one read and one write port. Timing is set by
// that single read port: free and query pass through the accepting state and
// one evaluation state, which loads the result register once the result slot
// is free; allocate stays in evaluation for each further map word it has to
// scan; clear sweeps every map word and then loads its result. A result that
// waits on m_axis_tready holds back the loading of the next result. After
// reset a clearing pass zeroes the map, during which s_axis_tready stays low;
// configuration writes are taken at all times. One request is in work at a
// time, and the next one is accepted while a result still waits on the master
// side. Blocks below first_data_block and at or above BLOCK_COUNT are never
// allocated; numbers above 1023 are reported in their low 10 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_core #(
	parameter int BLOCK_COUNT = bba_pkg::BLOCK_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// configuration write: first_data_block
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [9:0]  cfg_data,     // first_data_block

	// request stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata, // kind [1:0], block_number [11:2], zero [15:12]

	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata  // block_number_res [9:0], status [11:10],
	                                       // is_free [12], zero [15:13]
);

	bba_pkg::cmd_t                   cmd;
	bba_pkg::stat_t                  st;
	logic [bba_pkg::KIND_W-1:0]      in_kind;
	logic [bba_pkg::NUM_W-1:0]       in_num;
	logic [bba_pkg::NUM_W-1:0]       res_num;
	logic [bba_pkg::STATUS_W-1:0]    res_status;
	logic                            res_is_free;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// request fields
	assign in_kind = s_axis_tdata[1:0];
	assign in_num  = s_axis_tdata[11:2];

	// sequencing of scan, clear and read-modify-write
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_kind   (in_kind),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.st        (st)
	);

	// map memory, word search and result register
	bba_dp #(
		.BLOCK_COUNT (BLOCK_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.in_kind     (in_kind),
		.in_num      (in_num),
		.cmd         (cmd),
		.st          (st),
		.res_num     (res_num),
		.res_status  (res_status),
		.res_is_free (res_is_free)
	);

	// result packing, upper bits zero
	assign m_axis_tdata = {3'b000, res_is_free, res_status, res_num};

endmodule

`default_nettype wire
